// File: rtl/kdrs_pkg.sv
// Shared widths, register indexes and key codes for the key debounce/repeat scanner.
package kdrs_pkg;

  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned KEY_W   = 3;
  localparam int unsigned DB_W    = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t CFG_HOLD     = 2'd1;
  localparam cfg_idx_t CFG_REPEAT   = 2'd2;

  localparam key_t KEY_NONE   = 3'd0;
  localparam key_t KEY_CENTER = 3'd5;

  localparam logic [DB_W-1:0]   DB_TICKS_RST     = 8'd0;
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 16'd50;
  localparam logic [TICK_W-1:0] REPEAT_TICKS_RST = 16'd5;

endpackage

// File: rtl/key_debounce_repeat_scanner_unit.sv
// Top level of the key debounce, long-press and auto-repeat scanner.
// Each input item is one scan tick carrying five active-low button levels; every
// item produces exactly one result item (key_written, key_code, center_long_press).
// The tick is encoded, the debounce state machine and its counters advance and the
// result lands in the output register all in the cycle the item is accepted, so the
// block takes one item per clock while the result drains; out_valid rises in the
// next cycle, and in_ready stays high while the output register is empty or drained.
// Configuration (debounce_ticks, hold_ticks, repeat_ticks at indexes 0, 1, 2) is
// accepted every cycle; writes to index 3 are dropped and data is masked to width.
module key_debounce_repeat_scanner_unit (
  input  logic                clk,
  input  logic                rst_n,
  // scan tick channel
  input  logic                in_valid,
  output logic                in_ready,
  input  kdrs_pkg::level_t    in_button_levels,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_key_written,
  output kdrs_pkg::key_t      out_key_code,
  output logic                out_center_long_press,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  kdrs_pkg::cfg_idx_t  cfg_index,
  input  kdrs_pkg::cfg_data_t cfg_data
);
  import kdrs_pkg::*;

  typedef enum logic [1:0] {
    ST_RELEASED   = 2'd0,
    ST_PRESS_DB   = 2'd1,
    ST_PRESSED    = 2'd2,
    ST_RELEASE_DB = 2'd3
  } scan_state_t;

  // configuration registers
  logic [DB_W-1:0]   db_ticks_r;
  logic [TICK_W-1:0] hold_ticks_r;
  logic [TICK_W-1:0] repeat_ticks_r;

  // scanner state
  scan_state_t      state_r, state_nxt;
  logic [DB_W-1:0]  db_cnt_r, db_cnt_nxt;
  logic [CNT_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [CNT_W-1:0] rep_cnt_r, rep_cnt_nxt;
  key_t             latched_r, latched_nxt;

  // output register
  logic out_valid_r;
  logic written_r, written_nxt;
  key_t code_r, code_nxt;
  logic longp_r, longp_nxt;

  key_t             key;
  logic             in_acc;
  logic [DB_W-1:0]  db_inc;
  logic [CNT_W-1:0] hold_inc;
  logic [CNT_W-1:0] rep_inc;

  kdrs_prio_enc u_enc (
    .levels (in_button_levels),
    .code   (key)
  );

  // Accept a tick whenever the output register is free or being taken this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid             = out_valid_r;
  assign out_key_written       = written_r;
  assign out_key_code          = code_r;
  assign out_center_long_press = longp_r;

  // Saturating increments; all counters hold at their all-ones maximum.
  assign db_inc   = (db_cnt_r == '1)   ? db_cnt_r   : db_cnt_r + DB_W'(1);
  assign hold_inc = (hold_cnt_r == '1) ? hold_cnt_r : hold_cnt_r + CNT_W'(1);
  assign rep_inc  = (rep_cnt_r == '1)  ? rep_cnt_r  : rep_cnt_r + CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    db_cnt_nxt   = db_cnt_r;
    hold_cnt_nxt = hold_cnt_r;
    rep_cnt_nxt  = rep_cnt_r;
    latched_nxt  = latched_r;
    written_nxt  = 1'b0;
    code_nxt     = KEY_NONE;
    longp_nxt    = 1'b0;
    unique case (state_r)
      ST_RELEASED: begin
        // Any press starts a fresh debounce window.
        if (key != KEY_NONE) begin
          state_nxt  = ST_PRESS_DB;
          db_cnt_nxt = '0;
        end
      end
      ST_PRESS_DB: begin
        if (key == KEY_NONE) begin
          state_nxt = ST_RELEASED;
        end else begin
          db_cnt_nxt = db_inc;
          if (db_inc >= db_ticks_r) begin
            state_nxt   = ST_PRESSED;
            latched_nxt = key;
          end
        end
      end
      ST_PRESSED: begin
        if (key == KEY_NONE) begin
          state_nxt    = ST_RELEASE_DB;
          db_cnt_nxt   = '0;
          hold_cnt_nxt = '0;
        end else begin
          hold_cnt_nxt = hold_inc;
          if (hold_inc > CNT_W'(hold_ticks_r)) begin
            rep_cnt_nxt = rep_inc;
            if (key == KEY_CENTER) begin
              // Long press on center: flag it, restart the hold and suppress
              // the center code on release.
              longp_nxt    = 1'b1;
              hold_cnt_nxt = '0;
              latched_nxt  = KEY_NONE;
            end else if (rep_inc > CNT_W'(repeat_ticks_r)) begin
              // Repeat emits the key currently seen, not the latched one.
              rep_cnt_nxt = '0;
              written_nxt = 1'b1;
              code_nxt    = key;
            end
          end
        end
      end
      ST_RELEASE_DB: begin
        if (key == KEY_NONE) begin
          db_cnt_nxt = db_inc;
          if (db_inc >= db_ticks_r) begin
            state_nxt   = ST_RELEASED;
            written_nxt = 1'b1;
            code_nxt    = latched_r;
          end
        end else begin
          // Bounce: back to pressed, debounce count kept as is.
          state_nxt = ST_PRESSED;
        end
      end
      default: begin
        state_nxt = ST_RELEASED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_RELEASED;
      db_cnt_r       <= '0;
      hold_cnt_r     <= '0;
      rep_cnt_r      <= '0;
      latched_r      <= KEY_NONE;
      out_valid_r    <= 1'b0;
      db_ticks_r     <= DB_TICKS_RST;
      hold_ticks_r   <= HOLD_TICKS_RST;
      repeat_ticks_r <= REPEAT_TICKS_RST;
    end else begin
      if (in_acc) begin
        state_r    <= state_nxt;
        db_cnt_r   <= db_cnt_nxt;
        hold_cnt_r <= hold_cnt_nxt;
        rep_cnt_r  <= rep_cnt_nxt;
        latched_r  <= latched_nxt;
      end
      // Hold the result until taken; a new item refills it in the same cycle.
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DEBOUNCE: db_ticks_r     <= cfg_data[DB_W-1:0];
          CFG_HOLD:     hold_ticks_r   <= cfg_data[TICK_W-1:0];
          CFG_REPEAT:   repeat_ticks_r <= cfg_data[TICK_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      written_r <= written_nxt;
      code_r    <= code_nxt;
      longp_r   <= longp_nxt;
    end
  end

  // Never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

  // A long press never coincides with a key emission.
  a_longp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(longp_r && written_r))
    else $error("long press and key write in one result");

  // No code is shown without a write.
  a_code_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !written_r) |-> (code_r == KEY_NONE))
    else $error("key code without key_written");

  // The hold counter is idle outside the pressed states.
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELEASED || state_r == ST_PRESS_DB) |-> (hold_cnt_r == '0))
    else $error("hold counter running while released");

endmodule

// File: rtl/kdrs_prio_enc.sv
// Priority encoder: active-low button levels to key code, highest button wins.
module kdrs_prio_enc (
  input  kdrs_pkg::level_t levels,
  output kdrs_pkg::key_t   code
);
  import kdrs_pkg::*;

  always_comb begin
    code = KEY_NONE;
    for (int i = 0; i < LEVEL_W; i++) begin
      if (!levels[i]) begin
        code = KEY_W'(i + 1);
      end
    end
  end

endmodule
